// ===== design/gnfp_pkg.sv =====
`default_nettype none

package gnfp_pkg;

  // Build-time defaults
  localparam int unsigned MaxPayloadDef = 52;
  localparam int unsigned QueueDepth    = 2;

  // Frame framing bytes
  localparam logic [7:0] SyncOne  = 8'hB5;
  localparam logic [7:0] SyncTwo  = 8'h62;
  localparam logic [7:0] NavClass = 8'h01;

  // Message ids of the navigation class
  localparam logic [7:0] IdPosition = 8'h02;
  localparam logic [7:0] IdVelocity = 8'h12;
  localparam logic [7:0] IdSolution = 8'h06;
  localparam logic [7:0] IdUtc      = 8'h21;

  // Header length and the window of payload bytes that feed the latches
  localparam int unsigned HeadBytes = 6;
  localparam int unsigned StgFirst  = 4;
  localparam int unsigned StgBytes  = 20;

  // Configuration space
  localparam int unsigned CfgAddrW      = 3;
  localparam logic        RegAccLimit   = 1'b0;
  localparam logic [31:0] AccLimitReset = 32'd5000;

  typedef enum logic [2:0] {
    CodePosition = 3'd0,
    CodeVelocity = 3'd1,
    CodeSolution = 3'd2,
    CodeUtc      = 3'd3,
    CodeOther    = 3'd4
  } msg_code_e;

  // One checked frame on its way from the parser to the latch stage
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } frame_t;

  function automatic msg_code_e code_of(logic [7:0] id);
    msg_code_e c;
    unique case (id)
      IdPosition: c = CodePosition;
      IdVelocity: c = CodeVelocity;
      IdSolution: c = CodeSolution;
      IdUtc:      c = CodeUtc;
      default:    c = CodeOther;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/gnfp_front.sv =====
`default_nettype none

module gnfp_front #(
  parameter int unsigned MAX_PAYLOAD = gnfp_pkg::MaxPayloadDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              rx_valid_i,
  output logic                   rx_ready_o,
  output logic                   push_valid_o,
  output gnfp_pkg::frame_t       push_frame_o,
  input  wire logic              push_ready_i
);
  import gnfp_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_PAYLOAD + HeadBytes + 3);
  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [3:0] {
    PhSync1, PhSync2, PhClass, PhId, PhLenLo, PhLenHi, PhPayload, PhCkA, PhCkB
  } phase_e;

  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      sum_a_q, sum_a_d;
  logic [7:0]      sum_b_q, sum_b_d;
  logic [7:0]      chk_a_q, chk_a_d;
  logic [7:0]      stg_q [StgBytes];

  logic            acc;
  phase_e          phase;
  logic [PosW-1:0] end_pos;
  logic [PosW-1:0] pidx;
  logic            bad;
  logic            good;
  logic [7:0]      add_a;

  assign rx_ready_o = push_ready_i;
  assign acc        = rx_valid_i & push_ready_i;
  assign end_pos    = PosW'(HeadBytes) + PosW'(len_q);
  assign pidx       = pos_q - PosW'(HeadBytes);

  // Classify the incoming byte by its place in the frame
  always_comb begin
    priority if (pos_q == PosW'(0)) phase = PhSync1;
    else if (pos_q == PosW'(1))     phase = PhSync2;
    else if (pos_q == PosW'(2))     phase = PhClass;
    else if (pos_q == PosW'(3))     phase = PhId;
    else if (pos_q == PosW'(4))     phase = PhLenLo;
    else if (pos_q == PosW'(5))     phase = PhLenHi;
    else if (pos_q < end_pos)       phase = PhPayload;
    else if (pos_q == end_pos)      phase = PhCkA;
    else                            phase = PhCkB;
  end

  // Work out the next parser state
  always_comb begin
    pos_d   = pos_q + PosW'(1);
    len_d   = len_q;
    id_d    = id_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    chk_a_d = chk_a_q;
    bad     = 1'b0;
    good    = 1'b0;
    add_a   = sum_a_q + rx_byte_i;
    unique case (phase)
      PhSync1: bad = (rx_byte_i != SyncOne);
      PhSync2: bad = (rx_byte_i != SyncTwo);
      PhClass: begin
        bad     = (rx_byte_i != NavClass);
        sum_a_d = rx_byte_i;
        sum_b_d = rx_byte_i;
      end
      PhId: begin
        id_d    = rx_byte_i;
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      PhLenLo: begin
        bad     = (rx_byte_i > 8'(MAX_PAYLOAD));
        len_d   = LenW'(rx_byte_i);
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      PhLenHi, PhPayload: begin
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
      end
      PhCkA: chk_a_d = rx_byte_i;
      PhCkB: begin
        good  = (chk_a_q == sum_a_q) && (rx_byte_i == sum_b_q);
        pos_d = '0;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      pos_d = '0;
    end
  end

  // Hand a checked frame to the queue with its latch words gathered
  assign push_valid_o    = acc && (phase == PhCkB) && good;
  assign push_frame_o.id = id_q;
  assign push_frame_o.w0 = {stg_q[3], stg_q[2], stg_q[1], stg_q[0]};
  assign push_frame_o.w1 = {stg_q[7], stg_q[6], stg_q[5], stg_q[4]};
  assign push_frame_o.w2 = (id_q == IdPosition) ?
                           {stg_q[15], stg_q[14], stg_q[13], stg_q[12]} :
                           {stg_q[11], stg_q[10], stg_q[9], stg_q[8]};
  assign push_frame_o.w3 = {stg_q[19], stg_q[18], stg_q[17], stg_q[16]};

  // Advance the parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      id_q    <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= '0;
    end else if (acc) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      id_q    <= id_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      chk_a_q <= chk_a_d;
    end
  end

  // Keep payload bytes in the latch window; stale bytes stay between frames
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < StgBytes; k++) begin
        stg_q[k] <= '0;
      end
    end else if (acc && (phase == PhPayload)) begin
      for (int k = 0; k < StgBytes; k++) begin
        if (pidx == PosW'(k + StgFirst)) begin
          stg_q[k] <= rx_byte_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gnfp_queue.sv =====
`default_nettype none

module gnfp_queue #(
  parameter int unsigned DEPTH = gnfp_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_valid_i,
  input  wire gnfp_pkg::frame_t  wr_frame_i,
  output logic                   wr_ready_o,
  output logic                   rd_valid_o,
  output gnfp_pkg::frame_t       rd_frame_o,
  input  wire logic              rd_ready_i
);
  import gnfp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frame_t          mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign wr_ready_o = (cnt_q != CntW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_frame_o = mem[rd_ptr_q];
  assign wr_en      = wr_valid_i & wr_ready_o;
  assign rd_en      = rd_ready_i & rd_valid_o;

  // Store a frame at the write pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr_q] <= wr_frame_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gnfp_back.sv =====
`default_nettype none

module gnfp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              frm_valid_i,
  input  wire gnfp_pkg::frame_t  frm_i,
  output logic                   frm_ready_o,
  input  wire logic [31:0]       acc_limit_i,
  output logic                   msg_valid_o,
  input  wire logic              msg_ready_i,
  output logic [2:0]             msg_code_o,
  output logic [7:0]             msg_id_o,
  output logic                   pos_ok_o,
  output logic [31:0]            lon_o,
  output logic [31:0]            lat_o,
  output logic [31:0]            hgt_o,
  output logic [31:0]            hacc_o,
  output logic [31:0]            vn_o,
  output logic [31:0]            ve_o,
  output logic [31:0]            vd_o
);
  import gnfp_pkg::*;

  logic        out_valid_q;
  msg_code_e   code_q;
  logic [7:0]  id_q;
  logic        pok_q;
  logic [31:0] lon_q, lat_q, hgt_q, hacc_q;
  logic [31:0] vn_q, ve_q, vd_q;
  logic        load;

  // Take a frame whenever the result register is free or being drained
  assign frm_ready_o = !out_valid_q || msg_ready_i;
  assign load        = frm_valid_i && frm_ready_o;

  // Hold the result register valid until the request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frm_ready_o) begin
      out_valid_q <= frm_valid_i;
    end
  end

  // Latch fields; the latches double as the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= CodePosition;
      id_q   <= '0;
      pok_q  <= 1'b0;
      lon_q  <= '0;
      lat_q  <= '0;
      hgt_q  <= '0;
      hacc_q <= '0;
      vn_q   <= '0;
      ve_q   <= '0;
      vd_q   <= '0;
    end else if (load) begin
      code_q <= code_of(frm_i.id);
      id_q   <= frm_i.id;
      if (frm_i.id == IdPosition) begin
        lon_q  <= frm_i.w0;
        lat_q  <= frm_i.w1;
        hgt_q  <= frm_i.w2;
        hacc_q <= frm_i.w3;
        pok_q  <= (frm_i.w3 < acc_limit_i);
      end else if (frm_i.id == IdVelocity) begin
        vn_q <= frm_i.w0;
        ve_q <= frm_i.w1;
        vd_q <= frm_i.w2;
      end
    end
  end

  assign msg_valid_o = out_valid_q;
  assign msg_code_o  = code_q;
  assign msg_id_o    = id_q;
  assign pos_ok_o    = pok_q;
  assign lon_o       = lon_q;
  assign lat_o       = lat_q;
  assign hgt_o       = hgt_q;
  assign hacc_o      = hacc_q;
  assign vn_o        = vn_q;
  assign ve_o        = ve_q;
  assign vd_o        = vd_q;

endmodule

`default_nettype wire

// ===== design/gnss_nav_frame_parser.sv =====
// Channel    Direction  Handshake               Payload
// rx         in         rx_valid_i/rx_ready_o   rx_byte_i
// msg        out        msg_valid_o/msg_ready_i msg_code_o .. vel_down_o
// apb        in         psel/penable/pready     paddr, pwdata, prdata
//
// One byte is taken per cycle while the frame queue has room; a good frame
// is registered in the queue, then in the result register, before its request shows.
// The parser stalls only when the two-entry frame queue is full.
// Reset (async, active low) clears parser state, queue, latches and sets
// accuracy_limit to 5000. No clearing pass is needed.
`default_nettype none

module gnss_nav_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = gnfp_pkg::MaxPayloadDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic                          rx_valid_i,
  output logic                               rx_ready_o,
  output logic                               msg_valid_o,
  input  wire logic                          msg_ready_i,
  output logic [2:0]                         msg_code_o,
  output logic [7:0]                         msg_id_o,
  output logic                               pos_ok_o,
  output logic signed [31:0]                 longitude_o,
  output logic signed [31:0]                 latitude_o,
  output logic signed [31:0]                 height_msl_o,
  output logic [31:0]                        horiz_accuracy_o,
  output logic signed [31:0]                 north_vel_o,
  output logic signed [31:0]                 vel_east_o,
  output logic signed [31:0]                 vel_down_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gnfp_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import gnfp_pkg::*;

  logic        push_valid, push_ready;
  frame_t      push_frame;
  logic        pop_valid, pop_ready;
  frame_t      pop_frame;
  logic [31:0] acc_limit_q;
  logic [31:0] lon, lat, hgt, vn, ve, vd;
  logic        reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CfgAddrW-1] == RegAccLimit);
  assign prdata  = reg_sel ? acc_limit_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_limit_q <= AccLimitReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      acc_limit_q <= pwdata;
    end
  end

  gnfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .push_valid_o (push_valid),
    .push_frame_o (push_frame),
    .push_ready_i (push_ready)
  );

  gnfp_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_frame_i (push_frame),
    .wr_ready_o (push_ready),
    .rd_valid_o (pop_valid),
    .rd_frame_o (pop_frame),
    .rd_ready_i (pop_ready)
  );

  gnfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (pop_valid),
    .frm_i       (pop_frame),
    .frm_ready_o (pop_ready),
    .acc_limit_i (acc_limit_q),
    .msg_valid_o (msg_valid_o),
    .msg_ready_i (msg_ready_i),
    .msg_code_o  (msg_code_o),
    .msg_id_o    (msg_id_o),
    .pos_ok_o    (pos_ok_o),
    .lon_o       (lon),
    .lat_o       (lat),
    .hgt_o       (hgt),
    .hacc_o      (horiz_accuracy_o),
    .vn_o        (vn),
    .ve_o        (ve),
    .vd_o        (vd)
  );

  assign longitude_o  = $signed(lon);
  assign latitude_o   = $signed(lat);
  assign height_msl_o = $signed(hgt);
  assign north_vel_o  = $signed(vn);
  assign vel_east_o   = $signed(ve);
  assign vel_down_o   = $signed(vd);

endmodule

`default_nettype wire

// ===== design/gnfp_checker.sv =====
`default_nettype none

module gnfp_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          msg_valid_o,
  input  wire logic                          msg_ready_i,
  input  wire logic [2:0]                    msg_code_o,
  input  wire logic [7:0]                    msg_id_o,
  input  wire logic [31:0]                   horiz_accuracy_o,
  input  wire logic                          pready
);
  import gnfp_pkg::*;

  // Config port never inserts wait states
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // A stalled request holds its id and horizontal accuracy
  a_msg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && !msg_ready_i |=>
      msg_valid_o && $stable(msg_id_o) && $stable(horiz_accuracy_o))
    else $error("stalled request changed");

  // Codes stay within the defined set
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o |-> (msg_code_o <= CodeOther))
    else $error("message code out of range");

  // Position code goes with the position id, and only with it
  a_code_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o |-> ((msg_code_o == CodePosition) == (msg_id_o == IdPosition)))
    else $error("position code and id disagree");

  // Velocity code goes with the velocity id, and only with it
  a_code_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o |-> ((msg_code_o == CodeVelocity) == (msg_id_o == IdVelocity)))
    else $error("velocity code and id disagree");

endmodule

bind gnss_nav_frame_parser gnfp_checker u_gnfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .msg_valid_o      (msg_valid_o),
  .msg_ready_i      (msg_ready_i),
  .msg_code_o       (msg_code_o),
  .msg_id_o         (msg_id_o),
  .horiz_accuracy_o (horiz_accuracy_o),
  .pready           (pready)
);

`default_nettype wire
